FILE: rtl/core/mmio_region_range_table_defines.svh
// ----------------------------------------------------------------------------
// mmio region range table assertion macros
// shared concurrent check helpers, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef MMIO_REGION_RANGE_TABLE_DEFINES_SVH
`define MMIO_REGION_RANGE_TABLE_DEFINES_SVH

// same-cycle implication
`define MRRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mrrt_pkg.sv
// ----------------------------------------------------------------------------
// mrrt_pkg
// types, codes and stream layout for the mmio region range table
// ----------------------------------------------------------------------------
`default_nettype none

package mrrt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 64;
  localparam int HDL_W  = 8;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int ST_W   = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [ST_W-1:0]   status_t;

  localparam func_t FUNC_ACCESS     = 2'd0;
  localparam func_t FUNC_REGISTER   = 2'd1;
  localparam func_t FUNC_DEREGISTER = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_REJECTED  = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  // input tdata layout
  localparam int IN_ADDR_LO = 0;
  localparam int IN_SPAN_LO = IN_ADDR_LO + ADDR_W;
  localparam int IN_HDL_LO  = IN_SPAN_LO + ADDR_W;
  localparam int IN_WR_LO   = IN_HDL_LO + HDL_W;
  localparam int IN_LEN_LO  = IN_WR_LO + 1;
  localparam int IN_DATA_LO = IN_LEN_LO + LEN_W;
  localparam int IN_USED_W  = IN_DATA_LO + DATA_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_HIT_LO  = 0;
  localparam int OUT_HDL_LO  = OUT_HIT_LO + 1;
  localparam int OUT_ADDR_LO = OUT_HDL_LO + HDL_W;
  localparam int OUT_LEN_LO  = OUT_ADDR_LO + ADDR_W;
  localparam int OUT_WR_LO   = OUT_LEN_LO + LEN_W;
  localparam int OUT_DATA_LO = OUT_WR_LO + 1;
  localparam int OUT_USED_W  = OUT_DATA_LO + DATA_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic              fire;
    func_t             func;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] span;
    logic [HDL_W-1:0]  handler;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             hit;
    logic [HDL_W-1:0] handler;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/mmio_region_range_table.sv
// stages: an accepted item is held in the s1 registers, and its result is
//   registered in the output registers once the output stage can advance
// throughput: one item per cycle unless out_tready stalls the output, set by the
//   parallel compare of the address against every entry and a stored start-order matrix
// reset: clears entry valid bits and both handshake stages, no clearing pass
// ----------------------------------------------------------------------------
// mmio_region_range_table
// region table with register, deregister and access lookup over streams
// ----------------------------------------------------------------------------
`default_nettype none

`include "mmio_region_range_table_defines.svh"

module mmio_region_range_table #(
  parameter int ENTRIES = mrrt_pkg::ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // addr, span, handler_in, write_flag, access_len, write_data, zero pad
  input  wire logic [mrrt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  wire logic [mrrt_pkg::FUNC_W-1:0]        in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // hit, handler_out, fwd_addr, fwd_len, fwd_write_flag, fwd_data, zero pad
  output logic [mrrt_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // status
  output logic [mrrt_pkg::ST_W-1:0]               out_tuser
);

  logic                              s1_vld_r;
  mrrt_pkg::func_t                   s1_func_r;
  logic [mrrt_pkg::ADDR_W-1:0]       s1_addr_r;
  logic [mrrt_pkg::ADDR_W-1:0]       s1_span_r;
  logic [mrrt_pkg::HDL_W-1:0]        s1_hdl_r;
  logic                              s1_wr_r;
  logic [mrrt_pkg::LEN_W-1:0]        s1_len_r;
  logic [mrrt_pkg::DATA_W-1:0]       s1_data_r;

  logic                              out_vld_r;
  mrrt_pkg::status_t                 out_status_r;
  logic                              out_hit_r;
  logic [mrrt_pkg::HDL_W-1:0]        out_hdl_r;
  logic [mrrt_pkg::ADDR_W-1:0]       out_addr_r;
  logic [mrrt_pkg::LEN_W-1:0]        out_len_r;
  logic                              out_wr_r;
  logic [mrrt_pkg::DATA_W-1:0]       out_data_r;

  logic                              adv;
  logic                              fire;
  logic                              in_acc;
  logic                              is_access;
  mrrt_pkg::req_t                    req;
  mrrt_pkg::rsp_t                    rsp;

  assign adv       = !out_vld_r || out_tready;
  assign fire      = s1_vld_r && adv;
  assign in_tready = !s1_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign is_access = s1_func_r == mrrt_pkg::FUNC_ACCESS;

  assign req.fire    = fire;
  assign req.func    = s1_func_r;
  assign req.addr    = s1_addr_r;
  assign req.span    = s1_span_r;
  assign req.handler = s1_hdl_r;

  mrrt_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_tuser;
      s1_addr_r <= in_tdata[mrrt_pkg::IN_ADDR_LO +: mrrt_pkg::ADDR_W];
      s1_span_r <= in_tdata[mrrt_pkg::IN_SPAN_LO +: mrrt_pkg::ADDR_W];
      s1_hdl_r  <= in_tdata[mrrt_pkg::IN_HDL_LO +: mrrt_pkg::HDL_W];
      s1_wr_r   <= in_tdata[mrrt_pkg::IN_WR_LO];
      s1_len_r  <= in_tdata[mrrt_pkg::IN_LEN_LO +: mrrt_pkg::LEN_W];
      s1_data_r <= in_tdata[mrrt_pkg::IN_DATA_LO +: mrrt_pkg::DATA_W];
    end
    if (fire) begin
      out_status_r <= rsp.status;
      out_hit_r    <= rsp.hit;
      out_hdl_r    <= rsp.handler;
      out_addr_r   <= is_access ? s1_addr_r : '0;
      out_len_r    <= is_access ? s1_len_r  : '0;
      out_wr_r     <= is_access && s1_wr_r;
      out_data_r   <= is_access ? s1_data_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[mrrt_pkg::OUT_HIT_LO]                           = out_hit_r;
    out_tdata[mrrt_pkg::OUT_HDL_LO +: mrrt_pkg::HDL_W]        = out_hdl_r;
    out_tdata[mrrt_pkg::OUT_ADDR_LO +: mrrt_pkg::ADDR_W]      = out_addr_r;
    out_tdata[mrrt_pkg::OUT_LEN_LO +: mrrt_pkg::LEN_W]        = out_len_r;
    out_tdata[mrrt_pkg::OUT_WR_LO]                            = out_wr_r;
    out_tdata[mrrt_pkg::OUT_DATA_LO +: mrrt_pkg::DATA_W]      = out_data_r;
  end

  `MRRT_ASSERT_NEXT(a_fire_to_out, fire, out_tvalid, "processed item did not reach output")
  `MRRT_ASSERT_NOW(a_hit_done, out_tvalid && out_hit_r, out_status_r == mrrt_pkg::ST_DONE, "hit without done status")
  `MRRT_ASSERT_NOW(a_reject_clean, out_tvalid && (out_status_r == mrrt_pkg::ST_REJECTED), !out_hit_r && (out_hdl_r == '0), "rejected item carries a match")

endmodule

`default_nettype wire

FILE: rtl/core/mrrt_table.sv
// ----------------------------------------------------------------------------
// mrrt_table
// region entries, parallel containment compare and lowest-start select
// ----------------------------------------------------------------------------
`default_nettype none

module mrrt_table #(
  parameter int ENTRIES = mrrt_pkg::ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mrrt_pkg::req_t req,
  output mrrt_pkg::rsp_t     rsp
);

  logic [ENTRIES-1:0]              vld_r;
  logic [mrrt_pkg::ADDR_W-1:0]     start_r [ENTRIES];
  logic [mrrt_pkg::ADDR_W-1:0]     end_r   [ENTRIES];
  logic [mrrt_pkg::HDL_W-1:0]      hdl_r   [ENTRIES];
  // lt_r[i][j]: start of entry i below start of entry j
  logic [ENTRIES-1:0]              lt_r    [ENTRIES];

  logic [ENTRIES-1:0]              contain;
  logic [ENTRIES-1:0]              dup;
  logic [ENTRIES-1:0]              best;
  logic [ENTRIES-1:0]              new_below;
  logic [ENTRIES-1:0]              old_below;
  logic [ENTRIES-1:0]              free_oh;
  logic [mrrt_pkg::HDL_W-1:0]      best_hdl;
  logic [mrrt_pkg::ADDR_W-1:0]     end_nxt;
  logic                            hit;
  logic                            full;
  logic                            reg_ok;
  logic                            dereg_ok;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      contain[i]   = vld_r[i] && (start_r[i] <= req.addr) && (req.addr < end_r[i]);
      dup[i]       = vld_r[i] && (start_r[i] == req.addr);
      new_below[i] = req.addr < start_r[i];
      old_below[i] = start_r[i] < req.addr;
    end
  end

  // starts are unique, so at most one containing entry has no lower rival
  always_comb begin
    best_hdl = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      best[i] = contain[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (contain[j] && lt_r[j][i]) begin
          best[i] = 1'b0;
        end
      end
      if (best[i]) begin
        best_hdl = best_hdl | hdl_r[i];
      end
    end
  end

  assign hit      = |contain;
  assign full     = &vld_r;
  assign free_oh  = ~vld_r & (vld_r + ENTRIES'(1));
  assign end_nxt  = req.addr + req.span;
  assign reg_ok   = req.fire && (req.func == mrrt_pkg::FUNC_REGISTER) && !(|dup) && !full;
  assign dereg_ok = req.fire && (req.func == mrrt_pkg::FUNC_DEREGISTER) && hit;

  always_comb begin
    rsp = '0;
    case (req.func)
      mrrt_pkg::FUNC_ACCESS, mrrt_pkg::FUNC_DEREGISTER: begin
        rsp.status  = hit ? mrrt_pkg::ST_DONE : mrrt_pkg::ST_NOT_FOUND;
        rsp.hit     = hit;
        rsp.handler = best_hdl;
      end
      mrrt_pkg::FUNC_REGISTER: begin
        rsp.status = ((|dup) || full) ? mrrt_pkg::ST_REJECTED : mrrt_pkg::ST_DONE;
      end
      default: begin
        rsp.status = mrrt_pkg::ST_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (reg_ok) begin
      vld_r <= vld_r | free_oh;
    end else if (dereg_ok) begin
      vld_r <= vld_r & ~best;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_ok) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          start_r[i] <= req.addr;
          end_r[i]   <= end_nxt;
          hdl_r[i]   <= req.handler;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (free_oh[i] && free_oh[j]) begin
            lt_r[i][j] <= 1'b0;
          end else if (free_oh[i]) begin
            lt_r[i][j] <= new_below[j];
          end else if (free_oh[j]) begin
            lt_r[i][j] <= old_below[i];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_mmio_region_range_table.sv
// ----------------------------------------------------------------------------
// tb_mmio_region_range_table
// Drives register, deregister, access and spare-function items into the region
// table with random gaps on both streams. A shadow copy of the table predicts
// every result, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mmio_region_range_table;

  import mrrt_pkg::*;

  localparam func_t FUNC_SPARE   = 2'd3;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    DRAIN_CYCLES = 16;
  localparam int    PHASES       = 8;
  localparam int    PHASE_ITEMS  = 150;

  typedef struct packed {
    status_t           status;
    logic              hit;
    logic [HDL_W-1:0]  handler;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              wr;
    logic [DATA_W-1:0] data;
  } region_rsp_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;

  // shadow copy of the region table
  bit                shadow_valid [ENTRIES_DEF];
  logic [ADDR_W-1:0] shadow_start [ENTRIES_DEF];
  logic [ADDR_W-1:0] shadow_end   [ENTRIES_DEF];
  logic [HDL_W-1:0]  shadow_hdl   [ENTRIES_DEF];

  region_rsp_t       awaited_rsp[$];
  int                mismatches  = 0;
  int                cycle_count = 0;
  int                rx_hold     = 0;
  bit                idle_on     = 1'b1;
  logic [ADDR_W-1:0] cluster_base;

  mmio_region_range_table #(.ENTRIES(ENTRIES_DEF)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit is_live(int i);
    return shadow_valid[i] && (shadow_end[i] > shadow_start[i]);
  endfunction

  function automatic int valid_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES_DEF; i++) if (shadow_valid[i]) n++;
    return n;
  endfunction

  function automatic int dead_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES_DEF; i++) if (shadow_valid[i] && !is_live(i)) n++;
    return n;
  endfunction

  // containing region with the lowest start, -1 when none
  function automatic int containing_entry(logic [ADDR_W-1:0] a);
    int k;
    k = -1;
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (shadow_valid[i] && shadow_start[i] <= a && a < shadow_end[i]) begin
        if (k < 0 || shadow_start[i] < shadow_start[k]) k = i;
      end
    end
    return k;
  endfunction

  function automatic region_rsp_t apply_region_op(func_t f, logic [ADDR_W-1:0] a,
      logic [ADDR_W-1:0] span, logic [HDL_W-1:0] h, logic wr, logic [LEN_W-1:0] len,
      logic [DATA_W-1:0] d);
    region_rsp_t r;
    int          k;
    int          slot;
    bit          dup;
    r    = '0;
    slot = -1;
    dup  = 1'b0;
    case (f)
      FUNC_ACCESS: begin
        k = containing_entry(a);
        if (k >= 0) begin
          r.status  = ST_DONE;
          r.hit     = 1'b1;
          r.handler = shadow_hdl[k];
        end else begin
          r.status = ST_NOT_FOUND;
        end
        r.addr = a;
        r.len  = len;
        r.wr   = wr;
        r.data = d;
      end
      FUNC_REGISTER: begin
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (shadow_valid[i]) begin
            if (shadow_start[i] == a) dup = 1'b1;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (dup || slot < 0) begin
          r.status = ST_REJECTED;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_start[slot] = a;
          shadow_end[slot]   = a + span;
          shadow_hdl[slot]   = h;
          r.status           = ST_DONE;
        end
      end
      FUNC_DEREGISTER: begin
        k = containing_entry(a);
        if (k >= 0) begin
          shadow_valid[k] = 1'b0;
          r.status        = ST_DONE;
          r.hit           = 1'b1;
          r.handler       = shadow_hdl[k];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: r.status = ST_REJECTED;
    endcase
    return r;
  endfunction

  task automatic send_item(func_t f, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] span,
      logic [HDL_W-1:0] h, logic wr, logic [LEN_W-1:0] len, logic [DATA_W-1:0] d);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap  = idle_on ? $urandom_range(0, 5) : 0;
    word = '0;
    word[IN_ADDR_LO +: ADDR_W] = a;
    word[IN_SPAN_LO +: ADDR_W] = span;
    word[IN_HDL_LO  +: HDL_W]  = h;
    word[IN_WR_LO]             = wr;
    word[IN_LEN_LO  +: LEN_W]  = len;
    word[IN_DATA_LO +: DATA_W] = d;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    awaited_rsp.push_back(apply_region_op(f, a, span, h, wr, len, d));
  endtask

  task automatic do_register(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] span,
      logic [HDL_W-1:0] h);
    send_item(FUNC_REGISTER, a, span, h, 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)), rand64());
  endtask

  task automatic do_deregister(logic [ADDR_W-1:0] a);
    send_item(FUNC_DEREGISTER, a, rand64(), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand64());
  endtask

  task automatic do_access(logic [ADDR_W-1:0] a, logic wr, logic [LEN_W-1:0] len,
      logic [DATA_W-1:0] d);
    send_item(FUNC_ACCESS, a, rand64(), 8'($urandom_range(0, 255)), wr, len, d);
  endtask

  // address biased towards live regions and their edges
  function automatic logic [ADDR_W-1:0] pick_addr();
    int                live[$];
    int                i;
    logic [ADDR_W-1:0] width;
    for (int j = 0; j < ENTRIES_DEF; j++) if (is_live(j)) live.push_back(j);
    if (live.size() == 0) return ($urandom_range(0, 1) != 0) ? rand64()
        : cluster_base + 64'($urandom_range(0, 65535));
    i = live[$urandom_range(0, live.size() - 1)];
    width = shadow_end[i] - shadow_start[i];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return shadow_start[i] + (rand64() % width);
      5:             return shadow_end[i];
      6:             return shadow_start[i] - 1;
      7:             return cluster_base + 64'($urandom_range(0, 65535));
      default:       return rand64();
    endcase
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : rx_side
    region_rsp_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t result expected none actual status %h data %h", $time, out_tuser,
                   out_tdata);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("hit", want.hit, out_tdata[OUT_HIT_LO]);
          check_field("handler_out", want.handler, out_tdata[OUT_HDL_LO +: HDL_W]);
          check_field("fwd_addr", want.addr, out_tdata[OUT_ADDR_LO +: ADDR_W]);
          check_field("fwd_len", want.len, out_tdata[OUT_LEN_LO +: LEN_W]);
          check_field("fwd_write_flag", want.wr, out_tdata[OUT_WR_LO]);
          check_field("fwd_data", want.data, out_tdata[OUT_DATA_LO +: DATA_W]);
        end
        rx_hold = idle_on ? $urandom_range(0, 5) : 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_tready <= (rx_hold == 0);
    end
  end

  task automatic test_empty_table();
    do_access('1, 1'b1, 4'hF, '1);
    do_deregister(64'h0);
    send_item(FUNC_SPARE, rand64(), rand64(), 8'hFF, 1'b1, 4'hF, rand64());
  endtask

  // overlapping regions resolve to the lowest start
  task automatic test_overlap_order();
    do_register(64'h0, '1, 8'h11);
    do_register(64'h0, 64'h10, 8'h22);
    do_register(64'h100, 64'h100, 8'hAA);
    do_access(64'h150, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF);
    do_access(64'h0, 1'b0, 4'd0, 64'h0);
    do_access('1, 1'b1, 4'd1, '1);
    do_deregister(64'h150);
    do_access(64'h150, 1'b1, 4'd4, '1);
    do_access(64'h200, 1'b1, 4'd2, 64'h5A5A);
    do_deregister(64'h5);
  endtask

  // wrapped and zero-span regions never hit but still block their start
  task automatic test_wrap_and_empty();
    do_register('1, 64'h1, 8'h33);
    do_register(64'hFFFF_FFFF_FFFF_FF00, 64'h200, 8'h44);
    do_register(64'h1000, 64'h0, 8'h55);
    do_register(64'h1000, 64'h10, 8'h66);
    do_access(64'hFFFF_FFFF_FFFF_FF80, 1'b1, 4'd9, rand64());
    do_access(64'h1000, 1'b0, 4'hF, rand64());
    do_deregister(64'h50);
  endtask

  task automatic test_full_table();
    int n;
    n = 0;
    while (valid_count() < ENTRIES_DEF) begin
      do_register(64'h2000_0000 + n * 64'h100, 64'h80, 8'(n + 8'h80));
      n++;
    end
    do_register(64'h3000_0000, 64'h80, 8'hEE);
    do_access(64'h2000_0040, 1'b1, 4'd8, rand64());
  endtask

  task automatic test_random_mix();
    int                r;
    int                reg_cut;
    int                dereg_cut;
    int                live[$];
    int                i;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] span;
    for (int p = 0; p < PHASES; p++) begin
      idle_on      = (p % 4) != 3;
      cluster_base = rand64();
      reg_cut      = (p % 2 == 0) ? 45 : 15;
      dereg_cut    = (p % 2 == 0) ? 60 : 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < reg_cut) begin
          live.delete();
          for (int j = 0; j < ENTRIES_DEF; j++) if (shadow_valid[j]) live.push_back(j);
          i = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : 0;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: a = cluster_base + 64'($urandom_range(0, 65535));
            4, 5:       a = rand64();
            6, 7:       a = (live.size() > 0) ? shadow_start[i] : rand64();
            default:    a = pick_addr();
          endcase
          case ($urandom_range(0, 19))
            0:       span = 64'h0;
            1, 2:    span = rand64();
            3, 4, 5: span = 64'($urandom);
            default: span = 64'($urandom_range(1, 32'h2000));
          endcase
          if (dead_count() >= 4 && !(a + span > a)) span = 64'($urandom_range(1, 32'h2000));
          if (!(a + span > a) && !(a + 64'h1 > a)) a = a - 64'h4000;
          do_register(a, span, 8'($urandom_range(0, 255)));
        end else if (r < dereg_cut) begin
          do_deregister(pick_addr());
        end else if (r < 96) begin
          do_access(pick_addr(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    rand64());
        end else begin
          send_item(FUNC_SPARE, rand64(), rand64(), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand64());
        end
      end
    end
  endtask

  initial begin
    cluster_base = 64'h0000_00F0_0000_0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_overlap_order();
    test_wrap_and_empty();
    test_full_table();
    test_random_mix();
    in_tvalid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
